// ----- rtl/smls_pkg.sv -----
// Shared types and constants for the stepper move controller with limit stop.
package smls_pkg;

  localparam int POSITION_BITS = 16;
  localparam int INTERVAL_BITS = 20;

  // Difference of target and position needs one bit over the wider operand.
  localparam int DIFF_BITS = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;

  localparam logic signed [DIFF_BITS-1:0] DIFF_SAT_HI = DIFF_BITS'(32767);
  localparam logic signed [DIFF_BITS-1:0] DIFF_SAT_LO = DIFF_BITS'(-32768);

  localparam logic [INTERVAL_BITS-1:0] TICK_MAX = '1;
  localparam logic [19:0] STEP_INTERVAL_RESET = 20'd1000;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_REL  = 2'd1,
    CMD_ABS  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] amount;
    logic               open_switch;
    logic               closed_switch;
  } item_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos;
    logic                     dir;      // 1 toward open, 0 toward closed
    logic [15:0]              steps;
    logic [INTERVAL_BITS-1:0] ticks;
    logic                     moving;
  } state_t;

  typedef struct packed {
    logic [1:0]         coil_phase;
    logic               step_taken;
    logic signed [15:0] position_now;
    logic [15:0]        steps_undone;
    logic               busy_res;
    logic               limit_stop;
    logic               move_done;
  } result_t;

endpackage

// ----- rtl/smls_core.sv -----
// Next-state and result logic for one word of the stepper move controller.
module smls_core (
  input  smls_pkg::state_t  cur,
  input  smls_pkg::item_t   item,
  input  logic [19:0]       step_interval,
  output smls_pkg::state_t  nxt,
  output smls_pkg::result_t res
);
  import smls_pkg::*;

  logic signed [DIFF_BITS-1:0] amt_w;
  logic signed [DIFF_BITS-1:0] pos_w;
  logic signed [DIFF_BITS-1:0] diff_w;
  logic signed [15:0]          diff_sat;
  logic signed [15:0]          delta;
  logic [15:0]                 mag;
  logic [INTERVAL_BITS-1:0]    tick_inc;
  logic                        tick_due;
  logic [15:0]                 steps_dec;
  logic                        ahead_hit;
  logic                        stepped;
  logic                        lim;
  logic                        done;
  logic [31:0]                 pos_z;

  assign amt_w  = {{(DIFF_BITS-16){item.amount[15]}}, item.amount};
  assign pos_w  = {{(DIFF_BITS-POSITION_BITS){cur.pos[POSITION_BITS-1]}}, cur.pos};
  assign diff_w = amt_w - pos_w;

  always_comb begin
    if (diff_w > DIFF_SAT_HI) begin
      diff_sat = 16'sh7FFF;
    end else if (diff_w < DIFF_SAT_LO) begin
      diff_sat = 16'sh8000;
    end else begin
      diff_sat = diff_w[15:0];
    end
  end

  assign delta = (item.cmd == CMD_REL) ? item.amount : diff_sat;
  // Magnitude; the most negative value maps to 32768 unsigned.
  assign mag   = delta[15] ? 16'(-delta) : 16'(delta);

  assign tick_inc  = (cur.ticks < TICK_MAX) ? cur.ticks + 1'b1 : cur.ticks;
  assign tick_due  = 32'(tick_inc) >= 32'(step_interval);
  assign steps_dec = cur.steps - 16'd1;
  assign ahead_hit = cur.dir ? item.open_switch : item.closed_switch;

  always_comb begin
    nxt     = cur;
    stepped = 1'b0;
    lim     = 1'b0;
    done    = 1'b0;
    unique case (cmd_t'(item.cmd)) inside
      CMD_REL, CMD_ABS: begin
        if (delta != 16'sd0) begin
          nxt.dir = ~delta[15];
        end
        nxt.steps  = (delta == 16'sd0) ? 16'd0 : mag;
        nxt.moving = (delta != 16'sd0);
        done       = (delta == 16'sd0);
      end
      CMD_TICK: begin
        nxt.ticks = tick_inc;
        if (cur.moving && tick_due) begin
          nxt.ticks = '0;
          nxt.pos   = cur.dir ? cur.pos + 1'b1 : cur.pos - 1'b1;
          nxt.steps = steps_dec;
          stepped   = 1'b1;
          if (steps_dec == 16'd0) begin
            nxt.moving = 1'b0;
            done       = 1'b1;
          end else if (ahead_hit) begin
            nxt.moving = 1'b0;
            done       = 1'b1;
            lim        = 1'b1;
          end
        end
      end
      default: begin
        // unused code: state holds, status only
      end
    endcase
  end

  assign pos_z = 32'(nxt.pos);

  always_comb begin
    res.coil_phase   = nxt.pos[1:0];
    res.step_taken   = stepped;
    res.position_now = pos_z[15:0];
    res.steps_undone = nxt.steps;
    res.busy_res     = nxt.moving;
    res.limit_stop   = lim;
    res.move_done    = done;
  end

endmodule

// ----- rtl/stepper_move_with_limit_stop_unit.sv -----
// Top level of the stepper move controller with end-switch limit stop.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+----------------
//  in      | input     | in_cmd in_amount in_open/closed_switch  | in_valid/in_stall
//  out     | output    | out_coil_phase .. out_move_done         | out_valid/out_stall
//  cfg     | input     | cfg_write_data (step interval)          | cfg_write_en
//
// One word per clock cycle sustained while out does not stall; a word's result
// passes through the input register, then the result register. All stepping logic
// sits between those two registers and updates the motor state in the same cycle.
// Reset (synchronous, rst_n low) zeroes position, steps and direction, sets the
// tick counter to all ones and the step interval to 1000.
// A stall on out holds the result register; in then stalls only once the input
// register is also full, so one word can wait on each side.
module stepper_move_with_limit_stop_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic signed [15:0] in_amount,
  input  logic        in_open_switch,
  input  logic        in_closed_switch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_coil_phase,
  output logic        out_step_taken,
  output logic signed [15:0] out_position_now,
  output logic [15:0] out_steps_undone,
  output logic        out_busy_res,
  output logic        out_limit_stop,
  output logic        out_move_done,
  input  logic        cfg_write_en,
  input  logic [19:0] cfg_write_data
);
  import smls_pkg::*;

  item_t       in_r;
  logic        in_v_r;
  result_t     out_r;
  logic        out_v_r;
  state_t      st_r;
  logic [19:0] interval_r;

  state_t      st_nxt;
  result_t     res_nxt;
  logic        adv;

  // Result stage moves when empty or being taken.
  assign adv      = ~out_v_r | ~out_stall;
  assign in_stall = in_v_r & ~adv;

  smls_core u_core (
    .cur           (st_r),
    .item          (in_r),
    .step_interval (interval_r),
    .nxt           (st_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      interval_r  <= STEP_INTERVAL_RESET;
      st_r.pos    <= '0;
      st_r.dir    <= 1'b0;
      st_r.steps  <= '0;
      st_r.ticks  <= TICK_MAX;
      st_r.moving <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        interval_r <= cfg_write_data;
      end
      if (adv) begin
        out_v_r <= in_v_r;
        if (in_v_r) begin
          st_r <= st_nxt;
        end
      end
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (adv && in_v_r) begin
      out_r <= res_nxt;
    end
    if (!in_stall && in_valid) begin
      in_r.cmd           <= in_cmd;
      in_r.amount        <= in_amount;
      in_r.open_switch   <= in_open_switch;
      in_r.closed_switch <= in_closed_switch;
    end
  end

  assign out_valid        = out_v_r;
  assign out_coil_phase   = out_r.coil_phase;
  assign out_step_taken   = out_r.step_taken;
  assign out_position_now = out_r.position_now;
  assign out_steps_undone = out_r.steps_undone;
  assign out_busy_res     = out_r.busy_res;
  assign out_limit_stop   = out_r.limit_stop;
  assign out_move_done    = out_r.move_done;

  // A move in progress always has steps left.
  a_moving_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.moving |-> (st_r.steps != 16'd0))
    else $error("moving with no steps pending");

  // A limit stop is a step that ended the move with steps left over.
  a_limit_stop_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.limit_stop) |->
      (out_r.step_taken && out_r.move_done && !out_r.busy_res &&
       out_r.steps_undone != 16'd0))
    else $error("limit stop result inconsistent");

  // A busy result never reports completion.
  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.busy_res) |-> !out_r.move_done)
    else $error("busy and done together");

  // Input side stalls only while holding a word the result stage cannot take.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && out_stall))
    else $error("input stall without blocked word");

  // Coil phase follows the position's low bits.
  a_phase_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.coil_phase == out_r.position_now[1:0]))
    else $error("coil phase out of step with position");

endmodule
